>>> design/assert_macros.svh
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBF_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbf assertion failed");
`define SBF_NEVER(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("sbf forbidden condition seen");
`else
`define SBF_ASSERT(label, clk, rstn, prop)
`define SBF_NEVER(label, clk, rstn, prop)
`endif
`endif

>>> design/sbf_pkg.sv
package sbf_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CW  = 32;           // coordinate width
  localparam int unsigned DW  = CW + 1;       // difference width
  localparam int unsigned KW  = 31;           // spring constant width
  localparam int unsigned LW  = DW;           // length width
  localparam int unsigned RW  = 2 * LW;       // radicand width
  localparam int unsigned SW  = LW;           // stretch width
  localparam int unsigned PW  = KW + SW;      // k * s width
  localparam int unsigned MW  = PW - FRAC_BITS; // magnitude width
  localparam int unsigned ML  = 32;           // low split of magnitude
  localparam int unsigned NW  = DW + MW;      // numerator width
  localparam int unsigned QW  = 32;           // quotient bits kept
  localparam int unsigned NHW = NW - QW;      // numerator high part
  localparam int unsigned AW  = 4;            // apb address width
  localparam int unsigned XW  = 32;           // apb data width

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_K    = 2'd1;
  localparam logic [1:0] REG_REST = 2'd2;

  localparam logic MODE_SPRING = 1'b0;
  localparam logic MODE_BUNGEE = 1'b1;

  localparam logic [KW-1:0] K_RESET    = 31'd65536;
  localparam logic [KW-1:0] REST_RESET = 31'd0;

  localparam logic [CW-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic          mode;
    logic [KW-1:0] k;
    logic [KW-1:0] rest;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0] adx;
    logic [DW-1:0] ady;
    logic          negx;
    logic          negy;
  } vec_t;

  typedef struct packed {
    logic applied;
    logic zero;
    logic negx;
    logic negy;
  } flag_t;

  typedef struct packed {
    vec_t          v;
    flag_t         f;
    logic [LW-1:0] len;
  } mid_t;

endpackage

>>> design/sbf_in_if.sv
interface sbf_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   pos_x;
  logic signed [31:0]   pos_y;
  logic signed [31:0]   other_x;
  logic signed [31:0]   other_y;

  modport source (output valid, pos_x, pos_y, other_x, other_y, input ready);
  modport sink   (input valid, pos_x, pos_y, other_x, other_y, output ready);
endinterface

>>> design/sbf_out_if.sv
interface sbf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               force_applied;
  logic               saturated;

  modport source (output valid, force_x, force_y, force_applied, saturated, input ready);
  modport sink   (input valid, force_x, force_y, force_applied, saturated, output ready);
endinterface

>>> design/spring_bungee_force.sv
// channel   dir  transfer fields
// in_i      in   pos_x pos_y other_x other_y (signed Q16.16)
// out_o     out  force_x force_y force_applied saturated
// apb       in   mode, spring_constant, rest_length at 0x0 0x4 0x8
//
// one item per cycle while the output is not stalled; 74 register stages:
// 1 input, 1 square, 1 sum, 33 root stages (one bit each), 1 stretch,
// 1 k*s, 1 partial products, 1 numerator, 33 divider stages, 1 output.
// a stall at the output freezes the whole pipeline; nothing is dropped.
// reset clears valid bits and loads the register defaults.
`include "assert_macros.svh"

module spring_bungee_force (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sbf_in_if.sink                 in_i,
  sbf_out_if.source              out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [sbf_pkg::AW-1:0] paddr,
  input  logic [sbf_pkg::XW-1:0] pwdata,
  output logic [sbf_pkg::XW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned DW = sbf_pkg::DW;
  localparam int unsigned LW = sbf_pkg::LW;
  localparam int unsigned RW = sbf_pkg::RW;
  localparam int unsigned PW = sbf_pkg::PW;
  localparam int unsigned MW = sbf_pkg::MW;
  localparam int unsigned ML = sbf_pkg::ML;
  localparam int unsigned NW = sbf_pkg::NW;
  localparam int unsigned QW = sbf_pkg::QW;
  localparam int unsigned KW = sbf_pkg::KW;

  sbf_pkg::cfg_t cfg;

  sbf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic en;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vo_q;
  logic sq_vld, dv_vld;

  assign en         = !vo_q || out_o.ready;
  assign in_i.ready = en;

  // input stage: differences as magnitude and sign
  logic signed [DW-1:0] dx, dy;
  sbf_pkg::vec_t        vin, va_vec_q, vb_vec_q, vc_vec_q, sq_side;

  assign dx = {in_i.pos_x[31], in_i.pos_x} - {in_i.other_x[31], in_i.other_x};
  assign dy = {in_i.pos_y[31], in_i.pos_y} - {in_i.other_y[31], in_i.other_y};

  always_comb begin
    vin.adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    vin.ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    vin.negx = !dx[DW-1] && (dx != '0);
    vin.negy = !dy[DW-1] && (dy != '0);
  end

  logic [2*DW-1:0] sqx_q, sqy_q;
  logic [RW-1:0]   rad_q;
  logic [LW-1:0]   root;

  // stretch stage
  logic [LW-1:0]   restx;
  logic [LW-1:0]   s_d;
  sbf_pkg::mid_t   mid_d, md_q, me_q, mf_q, mg_q;
  logic [LW-1:0]   s_q;
  logic            slack;

  assign restx = {{(LW-KW){1'b0}}, cfg.rest};
  assign slack = (root <= restx);

  always_comb begin
    mid_d.v   = sq_side;
    mid_d.len = root;
    mid_d.f.negx = sq_side.negx;
    mid_d.f.negy = sq_side.negy;
    if (cfg.mode == sbf_pkg::MODE_BUNGEE) begin
      s_d            = root - restx;
      mid_d.f.applied = !slack;
      mid_d.f.zero    = slack || (root == '0);
    end else begin
      s_d            = (root >= restx) ? (root - restx) : (restx - root);
      mid_d.f.applied = 1'b1;
      mid_d.f.zero    = (root == '0);
    end
  end

  logic [PW-1:0]       prod;
  logic [MW-1:0]       mag_q;
  logic [DW+ML-1:0]    plox_q, ploy_q;
  logic [NW-ML-1:0]    phix_q, phiy_q;
  logic [NW-1:0]       nx_q, ny_q;

  assign prod = PW'(cfg.k) * PW'(s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= sq_vld;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      va_vec_q <= vin;
      sqx_q    <= (2*DW)'(va_vec_q.adx) * (2*DW)'(va_vec_q.adx);
      sqy_q    <= (2*DW)'(va_vec_q.ady) * (2*DW)'(va_vec_q.ady);
      vb_vec_q <= va_vec_q;
      rad_q    <= RW'(sqx_q) + RW'(sqy_q);
      vc_vec_q <= vb_vec_q;
      md_q   <= mid_d;
      s_q    <= s_d;
      mag_q  <= prod[PW-1:sbf_pkg::FRAC_BITS];
      me_q   <= md_q;
      plox_q <= (DW+ML)'(me_q.v.adx) * (DW+ML)'(mag_q[ML-1:0]);
      ploy_q <= (DW+ML)'(me_q.v.ady) * (DW+ML)'(mag_q[ML-1:0]);
      phix_q <= (NW-ML)'(me_q.v.adx) * (NW-ML)'(mag_q[MW-1:ML]);
      phiy_q <= (NW-ML)'(me_q.v.ady) * (NW-ML)'(mag_q[MW-1:ML]);
      mf_q   <= me_q;
      nx_q   <= {phix_q, {ML{1'b0}}} + NW'(plox_q);
      ny_q   <= {phiy_q, {ML{1'b0}}} + NW'(ploy_q);
      mg_q   <= mf_q;
    end
  end

  sbf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vc_q),
    .rad_i  (rad_q),
    .side_i (vc_vec_q),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  logic [QW-1:0]  qx, qy;
  logic           ovfx, ovfy;
  sbf_pkg::flag_t dflag;

  sbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vg_q),
    .nx_i   (nx_q),
    .ny_i   (ny_q),
    .len_i  (mg_q.len),
    .flag_i (mg_q.f),
    .vld_o  (dv_vld),
    .qx_o   (qx),
    .qy_o   (qy),
    .ovfx_o (ovfx),
    .ovfy_o (ovfy),
    .flag_o (dflag)
  );

  // clamp and sign
  logic [QW-1:0] fx_d, fy_d, fx_q, fy_q;
  logic          satx, saty, app_q, sat_q;

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (dflag.zero) begin
      fx_d = '0;
    end else if (dflag.negx) begin
      satx = ovfx || (qx > sbf_pkg::NEG_MAX);
      fx_d = satx ? sbf_pkg::NEG_MAX : (~qx + 1'b1);
    end else begin
      satx = ovfx || (qx > sbf_pkg::POS_MAX);
      fx_d = satx ? sbf_pkg::POS_MAX : qx;
    end
    if (dflag.zero) begin
      fy_d = '0;
    end else if (dflag.negy) begin
      saty = ovfy || (qy > sbf_pkg::NEG_MAX);
      fy_d = saty ? sbf_pkg::NEG_MAX : (~qy + 1'b1);
    end else begin
      saty = ovfy || (qy > sbf_pkg::POS_MAX);
      fy_d = saty ? sbf_pkg::POS_MAX : qy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      app_q <= dflag.applied;
      sat_q <= satx || saty;
    end
  end

  assign out_o.valid         = vo_q;
  assign out_o.force_x       = fx_q;
  assign out_o.force_y       = fy_q;
  assign out_o.force_applied = app_q;
  assign out_o.saturated     = sat_q;

  // slack cord carries no force
  `SBF_ASSERT(a_slack_zero, clk_i, rst_ni,
              (vo_q && !app_q) |-> (fx_q == '0 && fy_q == '0 && !sat_q))
  // a clamp lands on a range limit
  `SBF_ASSERT(a_sat_limit, clk_i, rst_ni,
              (vo_q && sat_q) |-> (fx_q == sbf_pkg::POS_MAX || fx_q == sbf_pkg::NEG_MAX ||
                                   fy_q == sbf_pkg::POS_MAX || fy_q == sbf_pkg::NEG_MAX))
  // nonzero force only when applied
  `SBF_NEVER(a_force_unapplied, clk_i, rst_ni,
             vo_q && !app_q && (fx_q != '0 || fy_q != '0))

endmodule

>>> design/sbf_cfg.sv
module sbf_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [sbf_pkg::AW-1:0]  paddr,
  input  logic [sbf_pkg::XW-1:0]  pwdata,
  output logic [sbf_pkg::XW-1:0]  prdata,
  output logic                    pready,
  output sbf_pkg::cfg_t           cfg_o
);

  sbf_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    idx;
  logic          wr;

  assign idx    = paddr[sbf_pkg::AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        sbf_pkg::REG_MODE: cfg_d.mode = pwdata[0];
        sbf_pkg::REG_K:    cfg_d.k    = pwdata[sbf_pkg::KW-1:0];
        sbf_pkg::REG_REST: cfg_d.rest = pwdata[sbf_pkg::KW-1:0];
        default:           cfg_d      = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbf_pkg::REG_MODE: prdata = {{(sbf_pkg::XW-1){1'b0}}, cfg_q.mode};
      sbf_pkg::REG_K:    prdata = {{(sbf_pkg::XW-sbf_pkg::KW){1'b0}}, cfg_q.k};
      sbf_pkg::REG_REST: prdata = {{(sbf_pkg::XW-sbf_pkg::KW){1'b0}}, cfg_q.rest};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= sbf_pkg::MODE_SPRING;
      cfg_q.k    <= sbf_pkg::K_RESET;
      cfg_q.rest <= sbf_pkg::REST_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/sbf_sqrt.sv
module sbf_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [sbf_pkg::RW-1:0] rad_i,
  input  sbf_pkg::vec_t          side_i,
  output logic                   vld_o,
  output logic [sbf_pkg::LW-1:0] root_o,
  output sbf_pkg::vec_t          side_o
);

  localparam int unsigned NS = sbf_pkg::LW;
  localparam int unsigned RW = sbf_pkg::RW;
  localparam int unsigned LW = sbf_pkg::LW;

  logic [NS-1:0] vld_q;
  logic [RW-1:0] rad_q  [NS];
  logic [RW-1:0] rad_d  [NS];
  logic [LW+1:0] rem_q  [NS];
  logic [LW+1:0] rem_d  [NS];
  logic [LW-1:0] root_q [NS];
  logic [LW-1:0] root_d [NS];
  sbf_pkg::vec_t side_q [NS];

  // one root bit per stage, two radicand bits brought down each time
  always_comb begin
    logic [RW-1:0] pr;
    logic [LW+1:0] pm;
    logic [LW-1:0] pt;
    logic [LW+3:0] rt;
    logic [LW+3:0] tr;
    logic [LW+3:0] rs;
    logic          ge;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        pr = rad_i;
        pm = '0;
        pt = '0;
      end else begin
        pr = rad_q[j-1];
        pm = rem_q[j-1];
        pt = root_q[j-1];
      end
      rt = {pm, pr[RW-1 -: 2]};
      tr = {2'b00, pt, 2'b01};
      rs = rt - tr;
      ge = (rt >= tr);
      rem_d[j]  = ge ? rs[LW+1:0] : rt[LW+1:0];
      root_d[j] = {pt[LW-2:0], ge};
      rad_d[j]  = {pr[RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NS; j++) begin
        rad_q[j]  <= rad_d[j];
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        side_q[j] <= (j == 0) ? side_i : side_q[j-1];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

>>> design/sbf_div.sv
module sbf_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [sbf_pkg::NW-1:0] nx_i,
  input  logic [sbf_pkg::NW-1:0] ny_i,
  input  logic [sbf_pkg::LW-1:0] len_i,
  input  sbf_pkg::flag_t         flag_i,
  output logic                   vld_o,
  output logic [sbf_pkg::QW-1:0] qx_o,
  output logic [sbf_pkg::QW-1:0] qy_o,
  output logic                   ovfx_o,
  output logic                   ovfy_o,
  output sbf_pkg::flag_t         flag_o
);

  localparam int unsigned QW  = sbf_pkg::QW;
  localparam int unsigned LW  = sbf_pkg::LW;
  localparam int unsigned NW  = sbf_pkg::NW;
  localparam int unsigned NHW = sbf_pkg::NHW;
  localparam int unsigned NS  = QW + 1;

  logic [NS-1:0]  vld_q;
  logic [LW-1:0]  rem_q [2][NS];
  logic [LW-1:0]  rem_d [2][NS];
  logic [QW-1:0]  low_q [2][NS];
  logic [QW-1:0]  low_d [2][NS];
  logic [QW-1:0]  q_q   [2][NS];
  logic [QW-1:0]  q_d   [2][NS];
  logic           ovf_q [2][NS];
  logic           ovf_d [2][NS];
  logic [LW-1:0]  len_q [NS];
  sbf_pkg::flag_t flag_q [NS];

  // first stage: quotient of 2^32 or more saturates, else remainder fits the length
  // later stages: one quotient bit each
  always_comb begin
    logic [NW-1:0] n;
    logic [LW:0]   rt;
    logic [LW:0]   rs;
    logic          ge;
    for (int c = 0; c < 2; c++) begin
      for (int j = 0; j < NS; j++) begin
        if (j == 0) begin
          n  = (c == 0) ? nx_i : ny_i;
          rt = '0;
          rs = '0;
          ge = 1'b0;
          ovf_d[c][j] = n[NW-1:QW] >= {{(NHW-LW){1'b0}}, len_i};
          rem_d[c][j] = n[QW+LW-1:QW];
          low_d[c][j] = n[QW-1:0];
          q_d[c][j]   = '0;
        end else begin
          n  = '0;
          rt = {rem_q[c][j-1], low_q[c][j-1][QW-1]};
          rs = rt - {1'b0, len_q[j-1]};
          ge = (rt >= {1'b0, len_q[j-1]});
          ovf_d[c][j] = ovf_q[c][j-1];
          rem_d[c][j] = ge ? rs[LW-1:0] : rt[LW-1:0];
          low_d[c][j] = {low_q[c][j-1][QW-2:0], 1'b0};
          q_d[c][j]   = {q_q[c][j-1][QW-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NS; j++) begin
        for (int c = 0; c < 2; c++) begin
          rem_q[c][j] <= rem_d[c][j];
          low_q[c][j] <= low_d[c][j];
          q_q[c][j]   <= q_d[c][j];
          ovf_q[c][j] <= ovf_d[c][j];
        end
        len_q[j]  <= (j == 0) ? len_i  : len_q[j-1];
        flag_q[j] <= (j == 0) ? flag_i : flag_q[j-1];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign qx_o   = q_q[0][NS-1];
  assign qy_o   = q_q[1][NS-1];
  assign ovfx_o = ovf_q[0][NS-1];
  assign ovfy_o = ovf_q[1][NS-1];
  assign flag_o = flag_q[NS-1];

endmodule

>>> tb/sv/tb_spring_bungee_force.sv
module tb_spring_bungee_force;

  localparam int unsigned WATCH_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               applied;
    logic               sat;
  } force_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [sbf_pkg::AW-1:0] paddr;
  logic [sbf_pkg::XW-1:0] pwdata;
  logic [sbf_pkg::XW-1:0] prdata;
  logic pready;

  sbf_in_if  in_ch ();
  sbf_out_if out_ch ();

  spring_bungee_force u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the register settings
  logic                   cur_mode;
  logic [sbf_pkg::KW-1:0] cur_k;
  logic [sbf_pkg::KW-1:0] cur_rest;

  force_t expected_forces[$];
  int     error_count;
  int     idle_cycles;
  bit     out_idle_en;
  bit     hold_sink;
  int     in_idle_pct;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] clamp_component(input logic signed [sbf_pkg::DW-1:0] d,
                                                  input logic [sbf_pkg::MW-1:0] mag,
                                                  input logic [sbf_pkg::LW-1:0] len,
                                                  inout logic sat);
    logic [sbf_pkg::DW-1:0] ad;
    logic [127:0]  q;
    ad = d[sbf_pkg::DW-1] ? -d : d;
    q = ({95'd0, ad} * {80'd0, mag}) / {95'd0, len};
    if (d > 0) begin
      if (q > 128'h8000_0000) begin
        q = 128'h8000_0000;
        sat = 1'b1;
      end
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) begin
      q = 128'h7fff_ffff;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic force_t predict_force(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] ox,
                                           input logic signed [31:0] oy);
    logic signed [sbf_pkg::DW-1:0] dx, dy;
    logic [sbf_pkg::DW-1:0] adx, ady;
    logic [sbf_pkg::RW-1:0] r;
    logic [sbf_pkg::LW-1:0] len, t, stretch, rest;
    logic [sbf_pkg::PW-1:0] prod;
    logic [sbf_pkg::MW-1:0] mag;
    force_t res;
    logic sat;
    dx = sbf_pkg::DW'(px) - sbf_pkg::DW'(ox);
    dy = sbf_pkg::DW'(py) - sbf_pkg::DW'(oy);
    adx = dx[sbf_pkg::DW-1] ? -dx : dx;
    ady = dy[sbf_pkg::DW-1] ? -dy : dy;
    r = sbf_pkg::RW'(adx) * sbf_pkg::RW'(adx) + sbf_pkg::RW'(ady) * sbf_pkg::RW'(ady);
    len = '0;
    for (int b = sbf_pkg::LW - 1; b >= 0; b--) begin
      t = len | (sbf_pkg::LW'(1) << b);
      if (sbf_pkg::RW'(t) * sbf_pkg::RW'(t) <= r) len = t;
    end
    rest = sbf_pkg::LW'(cur_rest);
    res = '0;
    res.applied = 1'b1;
    if (cur_mode == sbf_pkg::MODE_BUNGEE) begin
      if (len <= rest) begin
        res.applied = 1'b0;
        return res;
      end
      stretch = len - rest;
    end else begin
      stretch = (len >= rest) ? len - rest : rest - len;
    end
    if (len == '0) return res;
    prod = sbf_pkg::PW'(cur_k) * sbf_pkg::PW'(stretch);
    mag = prod[sbf_pkg::PW-1:sbf_pkg::FRAC_BITS];
    sat = 1'b0;
    res.fx = clamp_component(dx, mag, len, sat);
    res.fy = clamp_component(dy, mag, len, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sbf_pkg::AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sbf_pkg::REG_MODE: cur_mode = value[0];
      sbf_pkg::REG_K:    cur_k    = value[sbf_pkg::KW-1:0];
      sbf_pkg::REG_REST: cur_rest = value[sbf_pkg::KW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [31:0] k,
                            input logic [31:0] rest);
    wait_drained();
    write_reg(sbf_pkg::REG_MODE, {31'd0, mode});
    write_reg(sbf_pkg::REG_K, k);
    write_reg(sbf_pkg::REG_REST, rest);
  endtask

  // offers one item, idling at random before it, and waits for its transfer
  task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] ox, input logic [31:0] oy);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pos_x   <= px;
    in_ch.pos_y   <= py;
    in_ch.other_x <= ox;
    in_ch.other_y <= oy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_forces = {expected_forces, predict_force(px, py, ox, oy)};
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(200000)) - 100000);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return $urandom_range(1) ? sbf_pkg::POS_MAX : sbf_pkg::NEG_MAX;
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [31:0] px, py;
    for (int i = 0; i < n; i++) begin
      px = rand_coord();
      py = rand_coord();
      if ($urandom_range(9) == 0) send_item(px, py, px, py);
      else if ($urandom_range(3) == 0)
        send_item(px, py, px + 32'($urandom_range(1 << 20)),
                  py - 32'($urandom_range(1 << 20)));
      else send_item(px, py, rand_coord(), rand_coord());
    end
    end_burst();
  endtask

  task automatic test_reset_defaults();
    send_item(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h0, 32'h0, 32'h0);
    send_item(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    end_burst();
  endtask

  task automatic test_spring_extremes();
    set_config(sbf_pkg::MODE_SPRING, 32'h7fff_ffff, 32'h0005_0000);
    send_item(sbf_pkg::POS_MAX, sbf_pkg::POS_MAX, sbf_pkg::NEG_MAX, sbf_pkg::NEG_MAX);
    send_item(sbf_pkg::NEG_MAX, sbf_pkg::NEG_MAX, sbf_pkg::POS_MAX, sbf_pkg::POS_MAX);
    send_item(sbf_pkg::POS_MAX, 32'h0, sbf_pkg::NEG_MAX, 32'h0);
    send_item(32'h0, sbf_pkg::NEG_MAX, 32'h0, sbf_pkg::POS_MAX);
    send_item(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_item(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
    send_item(32'h0000_0001, 32'h0, 32'h0, 32'h0);
    end_burst();
    set_config(sbf_pkg::MODE_SPRING, 32'h0, 32'h7fff_ffff);
    send_item(sbf_pkg::POS_MAX, 32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h0, 32'h0, 32'h0);
    end_burst();
  endtask

  task automatic test_bungee_cases();
    set_config(sbf_pkg::MODE_BUNGEE, 32'h0002_0000, 32'h0005_0000);
    send_item(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    send_item(32'h0006_0000, 32'h0, 32'h0, 32'h0);
    send_item(32'hfffa_0000, 32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h0, 32'h0, 32'h0);
    send_item(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    end_burst();
    set_config(sbf_pkg::MODE_BUNGEE, 32'h7fff_ffff, 32'h0);
    send_item(sbf_pkg::POS_MAX, sbf_pkg::NEG_MAX, sbf_pkg::NEG_MAX, sbf_pkg::POS_MAX);
    send_item(32'h0, 32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h1, 32'h0, 32'h0);
    end_burst();
  endtask

  task automatic test_random_settings();
    logic [31:0] k_choice, rest_choice;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(3))
        0: k_choice = 32'($urandom_range(1 << 20));
        1: k_choice = $urandom;
        2: k_choice = 32'h7fff_ffff;
        default: k_choice = $urandom_range(1) ? 32'h0 : 32'h0001_0000;
      endcase
      case ($urandom_range(2))
        0: rest_choice = 32'($urandom_range(1 << 22));
        1: rest_choice = $urandom;
        default: rest_choice = $urandom_range(1) ? 32'h0 : 32'h7fff_ffff;
      endcase
      set_config(phase[0], k_choice, rest_choice);
      out_idle_en = (phase != 3);
      in_idle_pct = (phase == 3) ? 0 : 11;
      send_random(130);
    end
    out_idle_en = 1'b1;
    in_idle_pct = 11;
  endtask

  task automatic test_backpressure();
    set_config(sbf_pkg::MODE_SPRING, 32'h0003_0000, 32'h0002_0000);
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      send_random(150);
    join
    // sender pauses until everything is back
    while (expected_forces.size() != 0) @(posedge clk_i);
    send_random(60);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_sink && !(out_idle_en && $urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    force_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected result transfer", out_ch.force_x, 32'h0);
      end else begin
        want = expected_forces.pop_front();
        if (out_ch.force_x !== want.fx) report_mismatch("force_x", out_ch.force_x, want.fx);
        if (out_ch.force_y !== want.fy) report_mismatch("force_y", out_ch.force_y, want.fy);
        if (out_ch.force_applied !== want.applied)
          report_mismatch("force_applied", 32'(out_ch.force_applied), 32'(want.applied));
        if (out_ch.saturated !== want.sat)
          report_mismatch("saturated", 32'(out_ch.saturated), 32'(want.sat));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    out_idle_en = 1'b1;
    hold_sink   = 1'b0;
    in_idle_pct = 11;
    cur_mode = sbf_pkg::MODE_SPRING;
    cur_k    = sbf_pkg::K_RESET;
    cur_rest = sbf_pkg::REST_RESET;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.other_x = '0;
    in_ch.other_y = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_spring_extremes();
    test_bungee_cases();
    test_random_settings();
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
